// ===== hdl/sidta_pkg.sv =====
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none
package sidta_pkg;
    localparam int VALUE_BITS = 32;
    // Decimal digits needed for an unsigned VALUE_BITS-bit magnitude (log10(2) ~ 0.30103).
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int TOTAL_W    = 4;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic load;
        logic shift_digit;
    } sidta_ctrl_t;

    typedef struct packed {
        logic       running;
        logic [3:0] top_digit;
    } sidta_stat_t;
endpackage
`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii_top.sv =====
// Top level: signed integer to decimal ASCII characters, one character per strobe.
// After accept the block runs the conversion, then drops leading zero digits, then emits a '-' if negative
// and then the digits, most significant first.
// Busy stays high from accept until the last character is presented; no new item is taken while busy.
// Conversion uses the bit-serial shift-add-3 loop (one input bit per cycle) plus leading-zero skip.
// Characters then leave one per cycle; the receiver cannot stall them.
// Reset (rst_n low, asynchronous) returns to idle and drops any item in flight.
`default_nettype none
module signed_int_to_decimal_ascii_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [sidta_pkg::VALUE_BITS-1:0] value,
    output logic                                        strobe,
    output logic [7:0]                                  character,
    output logic                                        last,
    output logic [sidta_pkg::TOTAL_W-1:0]               total_chars
);
    import sidta_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_NORM, ST_SIGN, ST_EMIT} state_t;

    state_t               state_reg, state_next;
    logic                 neg_reg, neg_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 strobe_reg, strobe_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic [TOTAL_W-1:0]   tout_reg, tout_next;

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag;
    sidta_ctrl_t           ctrl;
    sidta_stat_t           stat;

    assign value_u = value;
    // Unsigned magnitude: the most negative value comes out exact.
    assign mag = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u) : value_u;

    sidta_dabble u_dabble (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .mag  (mag),
        .stat (stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        ndig_next        = ndig_reg;
        total_next       = total_reg;
        strobe_next      = 1'b0;
        char_next        = char_reg;
        last_next        = last_reg;
        tout_next        = tout_reg;
        ctrl.load        = 1'b0;
        ctrl.shift_digit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    neg_next   = value_u[VALUE_BITS-1];
                    ndig_next  = NDIG_W'(NUM_DIGITS);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!stat.running)
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Drop leading zero digits, keeping at least one.
                if (stat.top_digit == 4'd0 && ndig_reg != NDIG_W'(1))
                begin
                    ctrl.shift_digit = 1'b1;
                    ndig_next        = ndig_reg - NDIG_W'(1);
                end
                else
                begin
                    total_next = TOTAL_W'(ndig_reg) + TOTAL_W'(neg_reg);
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_MINUS;
                last_next   = (total_reg == TOTAL_W'(1));
                tout_next   = total_reg;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next      = 1'b1;
                char_next        = ASCII_ZERO + {4'd0, stat.top_digit};
                last_next        = (ndig_reg == NDIG_W'(1));
                tout_next        = total_reg;
                ctrl.shift_digit = 1'b1;
                ndig_next        = ndig_reg - NDIG_W'(1);
                if (ndig_reg == NDIG_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            neg_reg    <= 1'b0;
            ndig_reg   <= '0;
            total_reg  <= '0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
            tout_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            neg_reg    <= neg_next;
            ndig_reg   <= ndig_next;
            total_reg  <= total_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
            tout_reg   <= tout_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign character   = char_reg;
    assign last        = last_reg;
    assign total_chars = tout_reg;

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ($past(state_reg) == ST_SIGN || $past(state_reg) == ST_EMIT))
        else $error("strobe without an emitting state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        stat.running |-> (state_reg == ST_CONV))
        else $error("converter running outside conversion");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> (state_reg == ST_IDLE))
        else $error("last character while still emitting");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |=> (strobe_reg && char_reg == ASCII_MINUS))
        else $error("sign character missing");
endmodule
`default_nettype wire

// ===== hdl/sidta_dabble.sv =====
// Bit-serial shift-add-3 binary to BCD converter with a digit shift-out path.
`default_nettype none
module sidta_dabble (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sidta_pkg::sidta_ctrl_t          ctrl,
    input  wire logic [sidta_pkg::VALUE_BITS-1:0] mag,
    output sidta_pkg::sidta_stat_t               stat
);
    import sidta_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;

    // Add 3 to every digit that is 5 or more before the next shift.
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (ctrl.load)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                run_next = 1'b0;
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.running   = run_reg;
    assign stat.top_digit = bcd_reg[BCD_BITS-1 -: 4];
endmodule
`default_nettype wire

// ===== bench/signed_int_to_decimal_ascii_top_test.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
module signed_int_to_decimal_ascii_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sidta_pkg::*;

    typedef struct {
        logic [7:0]         code;
        logic               last;
        logic [TOTAL_W-1:0] count;
    } text_char_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [VALUE_BITS-1:0] value;
    logic                         strobe;
    logic [7:0]                   character;
    logic                         last;
    logic [TOTAL_W-1:0]           total_chars;

    text_char_t pending_chars[$];
    int         errors;

    signed_int_to_decimal_ascii_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .strobe      (strobe),
        .character   (character),
        .last        (last),
        .total_chars (total_chars)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Expected text of one value, most significant character first.
    function automatic void render_decimal(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            digits[$];
        logic                  neg;
        int                    total;
        int                    pos;
        text_char_t            c;
        neg = v[VALUE_BITS-1];
        // two's complement negate as unsigned: most negative value needs no fix-up
        mag = neg ? (~v + 1'b1) : v;
        do
        begin
            digits.push_front(ASCII_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        total = digits.size() + (neg ? 1 : 0);
        pos = 0;
        if (neg)
        begin
            c.code  = ASCII_MINUS;
            c.last  = (total == 1);
            c.count = TOTAL_W'(total);
            pending_chars.push_back(c);
            pos = 1;
        end
        foreach (digits[i])
        begin
            c.code  = digits[i];
            c.last  = (pos == total - 1);
            c.count = TOTAL_W'(total);
            pending_chars.push_back(c);
            pos++;
        end
    endfunction

    // Holds start high until the item is taken; start is left high for a following item.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        render_decimal(v);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        value <= $urandom;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 17));
    endtask

    // Value with a random digit count and sign, or fully random bits.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        logic   neg;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        ndig = $urandom_range(1, 10);
        neg  = $urandom_range(0, 1);
        lo   = (ndig == 1) ? 0 : 1;
        hi   = 9;
        for (int i = 1; i < ndig; i++)
        begin
            lo = lo * 10;
            hi = hi * 10 + 9;
        end
        if (hi > 64'sd2147483647)
            hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        mag = lo + $urandom_range(0, 32'(hi - lo));
        return VALUE_BITS'(neg ? -mag : mag);
    endfunction

    task automatic test_extremes();
        logic signed [VALUE_BITS-1:0] corner[] = '{
            0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
            999999999, -999999999, 1000000000, -1000000000,
            123456789, -123456789, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
            32'shAAAAAAAA, 32'sh55555555
        };
        foreach (corner[i])
        begin
            send_value(corner[i]);
            maybe_idle();
        end
    endtask

    task automatic test_random_values();
        repeat (84)
        begin
            send_value(pick_value());
            maybe_idle();
        end
    endtask

    task automatic test_back_to_back();
        repeat (25)
            send_value(pick_value());
        idle_cycles(1);
    endtask

    // Results cannot be stalled: every strobe is checked on the edge that ends it.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h", character));
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.code)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              character, want.code));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", last, want.last));
                if (total_chars !== want.count)
                    report_mismatch($sformatf("total_chars %0d, expected %0d",
                                              total_chars, want.count));
            end
        end
    end

    initial
    begin
        int waited;
        clk    = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        value  = '0;
        errors = 0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_random_values();
        test_back_to_back();

        waited = 0;
        while (pending_chars.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60)
            @(posedge clk);
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

        if (errors == 0)
            $display("signed_int_to_decimal_ascii_top_test: PASS");
        else
            $display("signed_int_to_decimal_ascii_top_test: FAIL");
        $finish;
    end

    initial
    begin
        #500000;
        $display("signed_int_to_decimal_ascii_top_test: FAIL");
        $finish;
    end
endmodule
